// ===== design/text_append_store_line_index_core_assert.svh =====
// Assertion macros for the text store with line index.
`ifndef TEXT_APPEND_STORE_LINE_INDEX_CORE_ASSERT_SVH
`define TEXT_APPEND_STORE_LINE_INDEX_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TASL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TASL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tasl_pkg.sv =====
// Shared constants, codes and types of the text store with line index.
`default_nettype none
package tasl_pkg;
   localparam int TEXT_DEPTH = 65536;
   localparam int LINE_DEPTH = 16384;
   localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
   localparam int FILL_W     = TEXT_AW + 1;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int CNT_W      = LINE_AW + 1;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 16;
   localparam int SPAN_W  = 17;
   localparam int REM_W   = 17;
   localparam int LINES_W = 15;
   localparam int STAT_W  = 2;
   localparam int TGT_W   = 18;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

   typedef struct packed {
      logic             start;
      logic [TGT_W-1:0] target;
   } srch_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] index;
   } srch_rsp_type;
endpackage
`default_nettype wire

// ===== design/tasl_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tasl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== design/tasl_search.sv =====
// Serial lower-bound search over the newline table; each probe passes through the PROBE and CMP states.
`default_nettype none
module tasl_search import tasl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire srch_req_type       req,
   input  wire logic [CNT_W-1:0]   total,
   output logic      [LINE_AW-1:0] rd_addr,
   input  wire logic [TEXT_AW-1:0] rd_data,
   output srch_rsp_type            rsp
);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_CMP   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [TGT_W-1:0] tgt_ff, tgt_in;
   logic [CNT_W:0]   sum;
   logic [CNT_W-1:0] mid;

   assign sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = sum[CNT_W:1];
   assign rd_addr = mid[LINE_AW-1:0];

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      tgt_in    = tgt_ff;
      rsp.done  = 1'b0;
      rsp.index = lo_ff;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_PROBE: begin
            if (lo_ff >= hi_ff) begin
               rsp.done = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (32'(rd_data) < 32'(tgt_ff)) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_PROBE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (req.start) begin
         lo_in    = '0;
         hi_in    = total;
         tgt_in   = req.target;
         state_in = S_PROBE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      tgt_ff <= tgt_in;
   end
endmodule
`default_nettype wire

// ===== design/text_append_store_line_index_core.sv =====
// Top level: append-only text store with a sorted index of newline positions.
// Append and unused commands: the result is registered at the accepting edge.
// Read: the text memory read is registered, then T_READ registers the byte; an out-of-range read answers at once.
// Count: two lower-bound searches, one in T_FIRST and one in T_LAST.
// A new item is taken only in the idle state, once the previous result has been taken or is leaving.
// Synchronous reset clears the fill and newline counts; both memories start undefined.
`default_nettype none
module text_append_store_line_index_core import tasl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CMD_W-1:0]   req_command,
   input  wire logic [BYTE_W-1:0]  req_data_byte,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [SPAN_W-1:0]  req_span_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [BYTE_W-1:0]  rsp_read_data,
   output logic      [REM_W-1:0]   rsp_bytes_remaining,
   output logic      [LINES_W-1:0] rsp_line_count,
   output logic      [STAT_W-1:0]  rsp_status
);
   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_READ  = 2'd1;
   localparam logic [1:0] T_FIRST = 2'd2;
   localparam logic [1:0] T_LAST  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [TGT_W-1:0]   last_tgt_ff, last_tgt_in;
   logic [CNT_W-1:0]   first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rd_ff, rd_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [LINES_W-1:0] lines_ff, lines_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;

   logic               accept;
   logic               is_newline;
   logic               append_ok;
   logic               text_wr_en;
   logic               line_wr_en;
   logic [BYTE_W-1:0]  text_rd_data;
   logic [TEXT_AW-1:0] line_rd_data;
   logic [LINE_AW-1:0] line_rd_addr;
   srch_req_type       srch_req;
   srch_rsp_type       srch_rsp;

   assign req_ready  = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign is_newline = (req_data_byte == NEWLINE_BYTE);
   assign append_ok  = (32'(fill_ff) < TEXT_DEPTH) &&
                       !(is_newline && (32'(total_ff) >= LINE_DEPTH));
   assign text_wr_en = accept && (req_command == CMD_APPEND) && append_ok;
   assign line_wr_en = text_wr_en && is_newline;

   tasl_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
      .clock   (clock),
      .wr_en   (text_wr_en),
      .wr_addr (fill_ff[TEXT_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (TEXT_AW'(req_position)),
      .rd_data (text_rd_data)
   );

   tasl_ram #(.WIDTH(TEXT_AW), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (total_ff[LINE_AW-1:0]),
      .wr_data (fill_ff[TEXT_AW-1:0]),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   tasl_search u_search (
      .clock   (clock),
      .reset   (reset),
      .req     (srch_req),
      .total   (total_ff),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data),
      .rsp     (srch_rsp)
   );

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      total_in        = total_ff;
      pos_in          = pos_ff;
      last_tgt_in     = last_tgt_ff;
      first_in        = first_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rd_in           = rd_ff;
      rem_in          = rem_ff;
      lines_in        = lines_ff;
      stat_in         = stat_ff;
      srch_req.start  = 1'b0;
      srch_req.target = TGT_W'(req_position);
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               pos_in      = req_position;
               last_tgt_in = TGT_W'(req_position) + TGT_W'(req_span_length);
               rd_in       = '0;
               rem_in      = '0;
               lines_in    = '0;
               stat_in     = ST_OK;
               unique case (req_command)
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (append_ok) begin
                        fill_in = fill_ff + FILL_W'(1);
                        if (is_newline) begin
                           total_in = total_ff + CNT_W'(1);
                        end
                     end else begin
                        stat_in = ST_FULL;
                     end
                  end
                  CMD_READ: begin
                     if (32'(req_position) >= 32'(fill_ff)) begin
                        rsp_valid_in = 1'b1;
                        stat_in      = ST_RANGE;
                     end else begin
                        state_in = T_READ;
                     end
                  end
                  CMD_COUNT: begin
                     srch_req.start = 1'b1;
                     state_in       = T_FIRST;
                  end
                  CMD_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         T_READ: begin
            rd_in        = text_rd_data;
            rem_in       = REM_W'(32'(fill_ff) - 32'(pos_ff));
            rsp_valid_in = 1'b1;
            state_in     = T_IDLE;
         end
         T_FIRST: begin
            if (srch_rsp.done) begin
               first_in        = srch_rsp.index;
               srch_req.start  = 1'b1;
               srch_req.target = last_tgt_ff;
               state_in        = T_LAST;
            end
         end
         T_LAST: begin
            if (srch_rsp.done) begin
               lines_in     = LINES_W'(srch_rsp.index - first_ff);
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      last_tgt_ff <= last_tgt_in;
      first_ff    <= first_in;
      rd_ff       <= rd_in;
      rem_ff      <= rem_in;
      lines_ff    <= lines_in;
      stat_ff     <= stat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rd_ff;
   assign rsp_bytes_remaining = rem_ff;
   assign rsp_line_count      = lines_ff;
   assign rsp_status          = stat_ff;
endmodule
`default_nettype wire

// ===== design/tasl_checker.sv =====
// Port-level checks of the text store results, bound to the top level.
`include "text_append_store_line_index_core_assert.svh"
`default_nettype none
module tasl_checker import tasl_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [BYTE_W-1:0]  rsp_read_data,
   input wire logic [REM_W-1:0]   rsp_bytes_remaining,
   input wire logic [LINES_W-1:0] rsp_line_count,
   input wire logic [STAT_W-1:0]  rsp_status
);
   `TASL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_bytes_remaining) && $stable(rsp_line_count) && $stable(rsp_read_data), "Stalled item changed")
   `TASL_ASSERT_NOW(a_status_code, rsp_valid, rsp_status == ST_OK || rsp_status == ST_RANGE || rsp_status == ST_FULL, "Unknown status code")
   `TASL_ASSERT_NOW(a_range_zero, rsp_valid && rsp_status != ST_OK, rsp_read_data == '0 && rsp_bytes_remaining == '0 && rsp_line_count == '0, "Failed item carries data")
   `TASL_ASSERT_NOW(a_read_no_lines, rsp_valid && rsp_bytes_remaining != '0, rsp_line_count == '0 && rsp_status == ST_OK, "Read item mixed with count")
endmodule

bind text_append_store_line_index_core tasl_checker u_tasl_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_text_append_store_line_index_core.sv =====
// Self-checking testbench for the append-only text store and its newline index.
`timescale 1ns / 100ps

module tb_text_append_store_line_index_core import tasl_pkg::*;;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic [REM_W-1:0]   bytes_remaining;
      logic [LINES_W-1:0] line_count;
      logic [STAT_W-1:0]  status;
   } text_reply_type;

   class line_index_scoreboard;
      bit [BYTE_W-1:0] stored_byte [TEXT_DEPTH];
      bit [POS_W-1:0]  newline_pos [LINE_DEPTH];
      int unsigned     bytes_stored;
      int unsigned     newlines_stored;
      text_reply_type  awaited_replies [$];
      int unsigned     error_count;

      function new();
         bytes_stored    = 0;
         newlines_stored = 0;
         error_count     = 0;
      endfunction

      function int unsigned first_line_at(int unsigned target);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = newlines_stored;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (newline_pos[mid] < target) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         return lo;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                 logic [POS_W-1:0] pos, logic [SPAN_W-1:0] span);
         text_reply_type reply;
         int unsigned    span_start;
         int unsigned    span_end;
         reply      = '0;
         span_start = pos;
         span_end   = span_start + span;
         case (cmd)
            CMD_APPEND: begin
               if (bytes_stored >= TEXT_DEPTH) begin
                  reply.status = ST_FULL;
               end else if (data == NEWLINE_BYTE && newlines_stored >= LINE_DEPTH) begin
                  reply.status = ST_FULL;
               end else begin
                  stored_byte[bytes_stored] = data;
                  if (data == NEWLINE_BYTE) begin
                     newline_pos[newlines_stored] = POS_W'(bytes_stored);
                     newlines_stored++;
                  end
                  bytes_stored++;
               end
            end
            CMD_READ: begin
               if (span_start >= bytes_stored) begin
                  reply.status = ST_RANGE;
               end else begin
                  reply.read_data       = stored_byte[pos];
                  reply.bytes_remaining = REM_W'(bytes_stored - span_start);
               end
            end
            CMD_COUNT: begin
               reply.line_count = LINES_W'(first_line_at(span_end) - first_line_at(span_start));
            end
            default: begin
            end
         endcase
         awaited_replies.insert(awaited_replies.size(), reply);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         error_count++;
         $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
      endtask

      task check_reply(logic [BYTE_W-1:0] rd, logic [REM_W-1:0] remain,
                       logic [LINES_W-1:0] lines, logic [STAT_W-1:0] st);
         text_reply_type want;
         if (awaited_replies.size() == 0) begin
            report_mismatch("unexpected item, status", st, 0);
         end else begin
            want = awaited_replies.pop_front();
            if (rd !== want.read_data) begin
               report_mismatch("read_data", rd, want.read_data);
            end
            if (remain !== want.bytes_remaining) begin
               report_mismatch("bytes_remaining", remain, want.bytes_remaining);
            end
            if (lines !== want.line_count) begin
               report_mismatch("line_count", lines, want.line_count);
            end
            if (st !== want.status) begin
               report_mismatch("status", st, want.status);
            end
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_command = CMD_NOP;
   logic [BYTE_W-1:0]  req_data_byte = '0;
   logic [POS_W-1:0]   req_position = '0;
   logic [SPAN_W-1:0]  req_span_length = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [BYTE_W-1:0]  rsp_read_data;
   logic [REM_W-1:0]   rsp_bytes_remaining;
   logic [LINES_W-1:0] rsp_line_count;
   logic [STAT_W-1:0]  rsp_status;

   bit                   no_idling = 1'b0;
   line_index_scoreboard index_check;

   text_append_store_line_index_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_data_byte       (req_data_byte),
      .req_position        (req_position),
      .req_span_length     (req_span_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_bytes_remaining (rsp_bytes_remaining),
      .rsp_line_count      (rsp_line_count),
      .rsp_status          (rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_text_append_store_line_index_core: errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && (no_idling || $urandom_range(99) >= 13);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         index_check.check_reply(rsp_read_data, rsp_bytes_remaining, rsp_line_count, rsp_status);
      end
   end

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                            logic [POS_W-1:0] pos, logic [SPAN_W-1:0] span);
      while (!no_idling && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_data_byte   <= data;
      req_position    <= pos;
      req_span_length <= span;
      do @(posedge clock); while (!req_ready);
      index_check.note_request(cmd, data, pos, span);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (index_check.awaited_replies.size() != 0);
   endtask

   task automatic send_random_read();
      int unsigned fill;
      int unsigned pos;
      fill = index_check.bytes_stored;
      if (fill == 0 || $urandom_range(9) == 0) begin
         pos = $urandom_range(65535);
      end else begin
         pos = $urandom_range(fill > 65535 ? 65535 : fill);
      end
      send_item(CMD_READ, BYTE_W'($urandom), POS_W'(pos), SPAN_W'($urandom));
   endtask

   task automatic send_random_count();
      int unsigned fill;
      int unsigned pos;
      int unsigned span;
      fill = index_check.bytes_stored;
      if ($urandom_range(7) == 0) begin
         pos = $urandom_range(65535);
      end else begin
         pos = $urandom_range(fill > 65530 ? 65535 : fill + 4);
      end
      case ($urandom_range(7)) inside
         [0:2]:   span = $urandom_range(16);
         [3:4]:   span = $urandom_range(fill + 8);
         5:       span = $urandom_range(131071);
         6:       span = 65536;
         default: span = 0;
      endcase
      send_item(CMD_COUNT, BYTE_W'($urandom), POS_W'(pos), SPAN_W'(span));
   endtask

   initial begin
      int unsigned       roll;
      logic [BYTE_W-1:0] pick;
      index_check = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty store: reads are out of range and the newline table is empty.
      send_item(CMD_READ, 8'h00, 16'd0, 17'd0);
      send_item(CMD_COUNT, 8'h00, 16'd0, 17'd65536);
      send_item(CMD_NOP, 8'hff, 16'hffff, 17'h1ffff);
      send_item(CMD_APPEND, 8'h00, 16'd0, 17'd0);
      send_item(CMD_APPEND, 8'hff, 16'hffff, 17'h1ffff);
      send_item(CMD_APPEND, NEWLINE_BYTE, 16'd0, 17'd0);
      send_item(CMD_APPEND, 8'h61, 16'd0, 17'd0);
      send_item(CMD_APPEND, NEWLINE_BYTE, 16'd0, 17'd0);
      send_item(CMD_READ, 8'h00, 16'd0, 17'd0);
      send_item(CMD_READ, 8'h00, 16'd4, 17'd0);
      send_item(CMD_READ, 8'h00, 16'd5, 17'd0);
      send_item(CMD_READ, 8'h00, 16'hffff, 17'd0);
      send_item(CMD_COUNT, 8'h00, 16'd0, 17'd0);
      send_item(CMD_COUNT, 8'h00, 16'd2, 17'd1);
      send_item(CMD_COUNT, 8'h00, 16'd3, 17'd1);
      send_item(CMD_COUNT, 8'h00, 16'd0, 17'h1ffff);
      send_item(CMD_COUNT, 8'h00, 16'hffff, 17'h1ffff);
      send_item(CMD_COUNT, 8'h00, 16'd2, 17'd3);
      send_item(CMD_COUNT, 8'h00, 16'd5, 17'd65536);
      send_item(CMD_NOP, 8'h00, 16'd0, 17'd0);
      send_item(CMD_APPEND, 8'h80, 16'd0, 17'd0);
      wait_for_replies();

      for (int i = 0; i < 460; i++) begin
         no_idling = (i >= 150 && i < 300);
         if (i % 97 == 96) begin
            wait_for_replies();
         end
         roll = $urandom_range(99);
         if (roll < 45) begin
            pick = ($urandom_range(3) == 0) ? NEWLINE_BYTE : BYTE_W'($urandom_range(255));
            send_item(CMD_APPEND, pick, POS_W'($urandom), SPAN_W'($urandom));
         end else if (roll < 70) begin
            send_random_read();
         end else if (roll < 96) begin
            send_random_count();
         end else begin
            send_item(CMD_NOP, BYTE_W'($urandom), POS_W'($urandom), SPAN_W'($urandom));
         end
      end
      no_idling = 1'b0;

      send_item(CMD_APPEND, 8'h41, 16'd0, 17'd0);
      send_item(CMD_APPEND, NEWLINE_BYTE, 16'd0, 17'd0);
      send_item(CMD_READ, 8'h00, 16'hffff, 17'd0);
      send_item(CMD_READ, 8'h00, 16'd0, 17'd0);
      send_item(CMD_COUNT, 8'h00, 16'd0, 17'd65536);
      send_item(CMD_COUNT, 8'h00, 16'hffff, 17'd65536);
      send_item(CMD_COUNT, 8'h00, 16'd0, 17'h1ffff);
      for (int i = 0; i < 20; i++) begin
         if ($urandom_range(1) == 0) begin
            send_random_read();
         end else begin
            send_random_count();
         end
      end

      wait_for_replies();
      repeat (70) @(posedge clock);
      if (index_check.awaited_replies.size() != 0) begin
         index_check.report_mismatch("items never returned", index_check.awaited_replies.size(), 0);
      end
      if (index_check.error_count == 0) begin
         $display("tb_text_append_store_line_index_core: clean");
      end else begin
         $display("tb_text_append_store_line_index_core: errors");
      end
      $finish;
   end
endmodule
